// ----- rtl/core/plwe_pkg.sv -----
// Shared types and constants for the parallel lane LED waveform encoder.
// No dependencies; imported by plwe_transpose and the top level.
package plwe_pkg;

    localparam int MAX_LANES    = 16;                 // width of one lane word
    localparam int LANES_DFLT   = 16;
    localparam int SLOT_BITS    = 24;                 // bits per LED, G R B
    localparam int COLOUR_W     = 24;
    localparam int LANE_W       = 4;
    localparam int CNT_W        = 5;                  // holds 0..SLOT_BITS-1
    localparam int ACT_W        = 5;                  // active lane count
    localparam int SLOT_W       = 64;

    localparam logic [CNT_W-1:0]     LAST_SLOT    = CNT_W'(SLOT_BITS - 1);
    localparam logic [ACT_W-1:0]     ACT_RESET    = ACT_W'(16);
    localparam logic [MAX_LANES-1:0] WORD_ONES    = 16'hFFFF;
    localparam logic [MAX_LANES-1:0] WORD_ZERO    = 16'h0000;

    typedef logic [COLOUR_W-1:0]  colour_t;   // {green, red, blue}
    typedef logic [MAX_LANES-1:0] mask_t;     // bit n = lane n

    // one accepted colour beat as seen by the transposer
    typedef struct packed {
        logic              hit;     // beat accepted this cycle for a lane below LANES
        logic [LANE_W-1:0] lane;
        colour_t           colour;
    } lane_wr_t;

endpackage

// ----- rtl/core/plwe_transpose.sv -----
// Bit transpose: per-lane colours (store merged with the incoming beat)
// become 24 lane masks, MSB of green first. Uses plwe_pkg.
module plwe_transpose
    import plwe_pkg::*;
#(
    parameter int LANES = LANES_DFLT
)
(
    input  colour_t          store [LANES],
    input  lane_wr_t         wr,
    input  logic [ACT_W-1:0] active_lanes,
    output mask_t            masks [SLOT_BITS]
);

    colour_t col [LANES];

    // newest beat wins over the stored entry
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            col[l] = store[l];
            if (wr.hit && ({1'b0, wr.lane} == 5'(l)))
            begin
                col[l] = wr.colour;
            end
        end
    end

    // lanes at or above the active count send zeros
    always_comb
    begin
        for (int k = 0; k < SLOT_BITS; k++)
        begin
            masks[k] = WORD_ZERO;
            for (int l = 0; l < LANES; l++)
            begin
                if (ACT_W'(l) < active_lanes)
                begin
                    masks[k][l] = col[l][SLOT_BITS-1-k];
                end
            end
        end
    end

endmodule

// ----- rtl/core/parallel_led_waveform_encoder_unit.sv -----
// Top level of the parallel lane LED waveform encoder: lane colour store,
// burst register and output stage. Depends on plwe_pkg and plwe_transpose.
//
//   channel  | direction | handshake          | beat
//   ---------+-----------+--------------------+-----------------------------------
//   in       | sink      | in_valid/in_stall  | lane, red, green, blue, last_lane,
//            |           |                    | last_led
//   out      | source    | out_valid/out_stall| slot_words, last_of_led,
//            |           |                    | end_of_frame
//   cfg      | sink      | cfg_wr_en          | cfg_wr_data (active lane count)
//
// Flow: a colour beat is taken every cycle unless it is stalled. A last_lane
// beat snapshots the whole LED position into the burst register, which
// then drains its 24 slot words, one per cycle while the output does not
// stall; colour beats for the next position keep flowing in meanwhile.
// A last_lane beat stalls only while the previous burst is still draining.
// Reset clears the colour store, the burst control and the output valid; the
// active lane count comes up as 16. A stalled output holds its word and
// pauses the burst.
module parallel_led_waveform_encoder_unit
    import plwe_pkg::*;
#(
    parameter int LANES = LANES_DFLT
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_wr_en,
    input  logic [ACT_W-1:0]    cfg_wr_data,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [LANE_W-1:0]   lane,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    input  logic                last_lane,
    input  logic                last_led,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [SLOT_W-1:0]   slot_words,
    output logic                last_of_led,
    output logic                end_of_frame
);

    // ------------------------------------------------------------------
    // Config
    // ------------------------------------------------------------------
    logic [ACT_W-1:0] active_lanes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_lanes_reg <= ACT_RESET;
        end
        else if (cfg_wr_en)
        begin
            active_lanes_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    logic     busy_reg;
    logic     in_acc;
    logic     lane_ok;
    lane_wr_t wr;

    // only a position-closing beat has to wait for the burst register
    assign in_stall = last_lane && busy_reg;
    assign in_acc   = in_valid && !in_stall;
    assign lane_ok  = ({1'b0, lane} < 5'(LANES));

    assign wr.hit    = in_acc && lane_ok;
    assign wr.lane   = lane;
    assign wr.colour = {green, red, blue};

    // colour store, cleared whenever a burst is taken
    colour_t store_reg [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (in_acc)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (last_lane)
                begin
                    store_reg[i] <= '0;
                end
                else if (wr.hit && ({1'b0, lane} == 5'(i)))
                begin
                    store_reg[i] <= wr.colour;
                end
            end
        end
    end

    mask_t masks [SLOT_BITS];

    plwe_transpose #(
        .LANES (LANES)
    ) u_transpose (
        .store        (store_reg),
        .wr           (wr),
        .active_lanes (active_lanes_reg),
        .masks        (masks)
    );

    // ------------------------------------------------------------------
    // Burst register: shift line of lane masks, head at index 0
    // ------------------------------------------------------------------
    mask_t            burst_reg [SLOT_BITS];
    logic [CNT_W-1:0] cnt_reg;
    logic             frame_reg;
    logic             snap;
    logic             load_out;
    logic             out_valid_reg;

    assign snap     = in_acc && last_lane;
    assign load_out = busy_reg && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk)
    begin
        if (snap)
        begin
            burst_reg <= masks;
        end
        else if (load_out)
        begin
            for (int k = 0; k < SLOT_BITS - 1; k++)
            begin
                burst_reg[k] <= burst_reg[k+1];
            end
            burst_reg[SLOT_BITS-1] <= WORD_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            frame_reg <= 1'b0;
        end
        else if (snap)
        begin
            busy_reg  <= 1'b1;
            cnt_reg   <= '0;
            frame_reg <= last_led;
        end
        else if (load_out)
        begin
            if (cnt_reg == LAST_SLOT)
            begin
                busy_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [SLOT_W-1:0] slot_words_reg;
    logic              last_of_led_reg;
    logic              end_of_frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            slot_words_reg   <= {WORD_ZERO, WORD_ZERO, burst_reg[0], WORD_ONES};
            last_of_led_reg  <= (cnt_reg == LAST_SLOT);
            end_of_frame_reg <= (cnt_reg == LAST_SLOT) && frame_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot_words   = slot_words_reg;
    assign last_of_led  = last_of_led_reg;
    assign end_of_frame = end_of_frame_reg;

`ifndef NO_ASSERTIONS
    // a burst is never taken on top of one still draining
    a_snap_free: assert property (@(posedge clk) disable iff (!rst_n)
        snap |-> !busy_reg)
        else $error("burst taken while busy");

    // idle burst engine sits at slot zero
    a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (cnt_reg == '0))
        else $error("slot counter not cleared");

    // counter stays inside the 24 slots
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_SLOT)
        else $error("slot counter out of range");

    // moving the last slot ends the burst
    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && (cnt_reg == LAST_SLOT)) |=> (!busy_reg && out_valid_reg
            && last_of_led_reg))
        else $error("burst did not end on last slot");

    // frame end only on an LED's final word
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && end_of_frame_reg) |-> last_of_led_reg)
        else $error("frame end without LED end");
`endif

endmodule
